// ===== hw/rtl/tsop_pkg.sv =====
// Shared types and constants for the one-shot temperature sensor poller.
// Beat layouts, command codes and configuration register indexes.
// No dependencies.
package tsop_pkg;

    localparam int ADDR_W    = 7;
    localparam int LIMIT_W   = 16;
    localparam int COUNT_W   = 17;
    localparam int BYTE_W    = 8;
    localparam int CMD_W     = 2;
    localparam int TDATA_W   = 24;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = LIMIT_W;

    localparam logic [LIMIT_W-1:0] ERROR_LIMIT_RST = 16'd2000;

    typedef enum logic [CMD_W-1:0] {
        CMD_NONE    = 2'd0,
        CMD_TRIGGER = 2'd1,
        CMD_READ    = 2'd2
    } t_cmd;

    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LIMIT    = 1'd1;

    // Input beat, lowest bit first: bus_accepts, result_present,
    // result_error, rx_high, rx_low, zero fill.
    typedef struct packed {
        logic [4:0]        pad;
        logic [BYTE_W-1:0] rx_low;
        logic [BYTE_W-1:0] rx_high;
        logic              result_error;
        logic              result_present;
        logic              bus_accepts;
    } t_in_beat;

    // Output beat, lowest bit first: command, target_address, bus_reset,
    // temp_valid, temperature, zero fill.
    typedef struct packed {
        logic [4:0]               pad;
        logic signed [BYTE_W-1:0] temperature;
        logic                     temp_valid;
        logic                     bus_reset;
        logic [ADDR_W-1:0]        target_address;
        t_cmd                     command;
    } t_out_beat;

endpackage

// ===== hw/rtl/temp_sensor_oneshot_poller_core.sv =====
// Top level of the one-shot temperature sensor poller.
// Uses tsop_pkg for beat layouts, command codes and register indexes.
//
// One poll tick enters per beat and yields exactly one result beat. A beat can
// be accepted every clock cycle when the output side is not stalled; each tick
// is held in the input register and leaves through the result register, which
// offers its result downstream. The four-phase sequencer, the failure counter
// compare and the conversion of the received word to whole degrees all sit in
// the single stage between those two registers. The result register doubles as
// the output buffer, so a new tick is taken while a finished result still
// waits. Configuration writes (device_address at index 0, error_limit at
// index 1) must be made while no tick is in flight.
module temp_sensor_oneshot_poller_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // bus_accepts, result_present, result_error, rx_high, rx_low, zero fill
    input  logic [tsop_pkg::TDATA_W-1:0]       i_s_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // command, target_address, bus_reset, temp_valid, temperature, zero fill
    output logic [tsop_pkg::TDATA_W-1:0]       o_m_tdata,
    input  logic                               i_cfg_we,
    input  logic [tsop_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [tsop_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_TRIG_WAIT = 2'd1,
        PH_READY     = 2'd2,
        PH_READ_WAIT = 2'd3
    } t_phase;

    logic                                r_in_valid;
    tsop_pkg::t_in_beat                  r_in;
    logic                                r_out_valid;
    tsop_pkg::t_out_beat                 r_out;
    tsop_pkg::t_out_beat                 n_out;
    t_phase                              r_phase;
    t_phase                              n_phase;
    logic [tsop_pkg::COUNT_W-1:0]        r_fail_count;
    logic [tsop_pkg::COUNT_W-1:0]        n_fail_count;
    logic [tsop_pkg::COUNT_W-1:0]        w_fail_inc;
    logic [tsop_pkg::ADDR_W-1:0]         r_device_address;
    logic [tsop_pkg::LIMIT_W-1:0]        r_error_limit;
    logic                                w_adv;
    logic signed [tsop_pkg::BYTE_W-1:0]  w_degrees;

    // Move the held tick into the result register when that slot is free.
    assign w_adv      = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_adv;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (i_s_tvalid && o_s_tready) begin
            r_in <= tsop_pkg::t_in_beat'(i_s_tdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_address <= '0;
            r_error_limit    <= tsop_pkg::ERROR_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                tsop_pkg::CFG_DEVICE_ADDRESS: begin
                    r_device_address <= i_cfg_wdata[tsop_pkg::ADDR_W-1:0];
                end
                tsop_pkg::CFG_ERROR_LIMIT: begin
                    r_error_limit <= i_cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    assign w_fail_inc = r_fail_count + 1'b1;

    // Signed word / 256 toward zero: high byte, bumped up when negative
    // and the low byte leaves a remainder.
    assign w_degrees = $signed(r_in.rx_high)
                     + $signed({7'd0, r_in.rx_high[7] && (r_in.rx_low != '0)});

    always_comb begin
        n_phase      = r_phase;
        n_fail_count = r_fail_count;
        n_out        = '0;
        n_out.command = tsop_pkg::CMD_NONE;
        unique case (r_phase)
            PH_IDLE: begin
                n_out.command = tsop_pkg::CMD_TRIGGER;
                if (r_in.bus_accepts) begin
                    n_phase = PH_TRIG_WAIT;
                end
            end
            PH_TRIG_WAIT: begin
                if (r_in.result_present) begin
                    if (r_in.result_error) begin
                        n_phase = PH_IDLE;
                        if (w_fail_inc > {1'b0, r_error_limit}) begin
                            n_out.bus_reset = 1'b1;
                            n_fail_count    = '0;
                        end else begin
                            n_fail_count = w_fail_inc;
                        end
                    end else begin
                        n_phase      = PH_READY;
                        n_fail_count = '0;
                    end
                end
            end
            PH_READY: begin
                n_out.command = tsop_pkg::CMD_READ;
                if (r_in.bus_accepts) begin
                    n_phase = PH_READ_WAIT;
                end
            end
            PH_READ_WAIT: begin
                if (r_in.result_present) begin
                    if (r_in.result_error) begin
                        // retry the read, errors here are not counted
                        n_phase = PH_READY;
                    end else begin
                        n_out.temp_valid  = 1'b1;
                        n_out.temperature = w_degrees;
                        n_phase           = PH_IDLE;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
        if (n_out.command != tsop_pkg::CMD_NONE) begin
            n_out.target_address = r_device_address;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_fail_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_adv) begin
                r_phase      <= n_phase;
                r_fail_count <= n_fail_count;
                r_out_valid  <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    // Count never reaches the top bit: it is cleared once past a 16-bit limit.
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fail_count[tsop_pkg::COUNT_W-1] == 1'b0)
        else $error("fail count overflowed its range");

    a_reset_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && n_out.bus_reset |=> r_fail_count == '0)
        else $error("bus reset without clearing the fail count");

    a_phase_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_phase) && $stable(r_fail_count))
        else $error("poller state moved without a tick");

    a_reading_no_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.temp_valid |->
            r_out.command == tsop_pkg::CMD_NONE && !r_out.bus_reset)
        else $error("reading delivered together with a command or reset");

    a_addr_only_with_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.command == tsop_pkg::CMD_NONE |->
            r_out.target_address == '0)
        else $error("target address driven without a command");

endmodule
